>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must hold at every clock edge outside reset
`define AST_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// when ante holds, cons must hold at the same edge
`define AST_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define AST_ALWAYS(lbl, clk, rst, cond, msg)
`define AST_IMPLIES(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/lcav_pkg.sv
// ----------------------------------------------------------------------------
// lcav_pkg
// Types, widths and constants of the lidar clearance block.
// ----------------------------------------------------------------------------
package lcav_pkg;

   // field widths
   localparam int CMD_W      = 2;
   localparam int IDX_W      = 10;
   localparam int RANGE_W    = 16;
   localparam int ANG_W      = 16;
   localparam int DIST_W     = 12;
   localparam int OUT_W      = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // radix-16 shift-add multiplier: 17-bit multiplicand, 20-bit multiplier
   localparam int MUL_A_W     = 17;
   localparam int DIGIT_W     = 4;
   localparam int MUL_DIGITS  = 5;
   localparam int MUL_B_W     = DIGIT_W * MUL_DIGITS;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int MUL_SUM_W   = MUL_A_W + DIGIT_W;
   localparam int DIG_CNT_W   = 3;

   // bit-pair square root of a squared distance
   localparam int SQ_W       = 34;
   localparam int ROOT_W     = 17;
   localparam int REM_W      = 18;
   localparam int SQ_STEPS   = 17;
   localparam int SQ_CNT_W   = 5;

   // scan geometry; trig depth is a power of two, so quantising is a mask
   localparam int MAX_SAMPLES      = 1024;
   localparam int TRIG_TABLE_DEPTH = 1024;
   localparam int TRIG_DROP        = ANG_W - $clog2(TRIG_TABLE_DEPTH);
   localparam logic [ANG_W-1:0] ANGLE_MASK = ~((16'd1 << TRIG_DROP) - 16'd1);
   localparam logic [ANG_W-1:0] QUARTER    = 16'd16384;

   // sine polynomial coefficients
   localparam logic [MUL_A_W-1:0] SIN_C1 = 17'd2320;
   localparam logic [MUL_A_W-1:0] SIN_C2 = 17'd21023;
   localparam logic [MUL_A_W-1:0] SIN_C3 = 17'd51472;

   localparam logic [30:0]        ROUND_HALF       = 31'd16384;
   localparam logic [SQ_W-1:0]    AHEAD_DEFAULT_SQ = 34'd100000000;
   localparam logic [RANGE_W-1:0] SIDE_DEFAULT     = 16'd10000;
   localparam logic [OUT_W-1:0]   EMPTY_DEFAULT    = 15'd10000;
   localparam logic [OUT_W-1:0]   OUT_MAX          = 15'd32767;
   localparam logic [RANGE_W-1:0] NO_RETURN        = 16'hFFFF;

   // register reset values
   localparam logic [ANG_W-1:0]  START_RESET  = 16'd0;
   localparam logic [ANG_W-1:0]  STEP_RESET   = 16'd64;
   localparam logic [DIST_W-1:0] OFFSET_RESET = 12'd150;
   localparam logic [DIST_W-1:0] HALF_W_RESET = 12'd400;

   typedef enum logic [CMD_W-1:0] {
      CMD_FRONT = 2'd0,
      CMD_BACK  = 2'd1,
      CMD_END   = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRONT_START  = 3'd0,
      REG_FRONT_STEP   = 3'd1,
      REG_BACK_START   = 3'd2,
      REG_BACK_STEP    = 3'd3,
      REG_AHEAD_OFFSET = 3'd4,
      REG_HALF_WIDTH   = 3'd5
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_POST,
      ST_UPDATE,
      ST_SQRT,
      ST_DONE
   } state_type;

   // product sequence for one sample
   typedef enum logic [3:0] {
      OP_ANGLE,
      OP_SZ2,
      OP_ST1,
      OP_ST2,
      OP_ST3,
      OP_CZ2,
      OP_CT1,
      OP_CT2,
      OP_CT3,
      OP_X,
      OP_Y,
      OP_DX,
      OP_DY
   } op_type;

   // folded argument of the sine polynomial, Q15, up to 32768
   function automatic logic [15:0] sine_z(input logic [ANG_W-1:0] ang);
      logic [14:0] u;
      u = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
      return {u, 1'b0};
   endfunction

   function automatic logic [OUT_W-1:0] clamp_q15(input logic [15:0] t);
      return t[15] ? OUT_MAX : t[14:0];
   endfunction

   function automatic logic [OUT_W-1:0] sat_root(input logic [ROOT_W-1:0] r);
      return (r[ROOT_W-1:OUT_W] != '0) ? OUT_MAX : r[OUT_W-1:0];
   endfunction

   function automatic logic [OUT_W-1:0] side_out(input logic [RANGE_W-1:0] a,
                                                 input logic [RANGE_W-1:0] b,
                                                 input logic [DIST_W-1:0]  h);
      logic [RANGE_W-1:0] m;
      logic [RANGE_W-1:0] diff;
      m    = (a < b) ? a : b;
      diff = m - {4'b0, h};
      if (m <= {4'b0, h}) return '0;
      return diff[15] ? OUT_MAX : diff[14:0];
   endfunction

endpackage

>>> rtl/lidar_clearance_around_vehicle.sv
// ----------------------------------------------------------------------------
// lidar_clearance_around_vehicle
// Front/back lidar samples to x,y points, minimum clearances per frame.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req_    | in  | req_valid/req_ready  | cmd, sample_index, range_mm
//  rsp_    | out | rsp_valid/rsp_ready  | front_mm, back_mm, left_mm, right_mm
//  csr_    | in  | csr_wr_en            | csr_index, csr_wdata
//
//  One beat at a time. A sample beside the vehicle runs 11 products on the
//  shared radix-16 multiplier and one ahead of it 12 or 13. An end beat runs two
//  17-step square roots unless a scanner was empty; ignored and no-return
//  samples are taken without leaving idle. Synchronous reset restores the
//  configuration and clears the frame. A waiting result blocks nothing but the
//  next end beat, which holds in its final state until the output register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lidar_clearance_around_vehicle
   import lcav_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [IDX_W-1:0]      req_sample_index,
   input  logic [RANGE_W-1:0]    req_range_mm,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUT_W-1:0]      rsp_front_mm,
   output logic [OUT_W-1:0]      rsp_back_mm,
   output logic [OUT_W-1:0]      rsp_left_mm,
   output logic [OUT_W-1:0]      rsp_right_mm,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   // configuration
   logic [ANG_W-1:0]  f_start_ff, f_start_in, f_step_ff, f_step_in;
   logic [ANG_W-1:0]  b_start_ff, b_start_in, b_step_ff, b_step_in;
   logic [DIST_W-1:0] offset_ff, offset_in, half_w_ff, half_w_in;

   // frame accumulators
   logic [SQ_W-1:0]    f_ahead_ff, f_ahead_in, b_ahead_ff, b_ahead_in;
   logic [RANGE_W-1:0] f_sneg_ff, f_sneg_in, f_spos_ff, f_spos_in;
   logic [RANGE_W-1:0] b_spos_ff, b_spos_in, b_sneg_ff, b_sneg_in;
   logic               f_seen_ff, f_seen_in, b_seen_ff, b_seen_in;

   // multiplier
   logic [DIG_CNT_W-1:0] dig_ff, dig_in;
   logic [MUL_A_W-1:0]   mul_a_ff, mul_a_in;
   logic [MUL_P_W-1:0]   prod_ff, prod_in;
   logic [MUL_SUM_W-1:0] mul_sum;

   // per-sample working registers
   logic               back_ff, back_in;
   logic [RANGE_W-1:0] range_ff, range_in;
   logic [ANG_W-1:0]   ang_ff, ang_in;
   logic [15:0]        z_ff, z_in, z2_ff, z2_in;
   logic [OUT_W-1:0]   s_mag_ff, s_mag_in;
   logic               s_neg_ff, s_neg_in, c_neg_ff, c_neg_in;
   logic [RANGE_W-1:0] x_mag_ff, x_mag_in, y_mag_ff, y_mag_in;
   logic [SQ_W-1:0]    d_ff, d_in;

   // square root
   logic [SQ_W-1:0]     sq_v_ff, sq_v_in;
   logic [REM_W-1:0]    sq_rem_ff, sq_rem_in;
   logic [ROOT_W-1:0]   sq_root_ff, sq_root_in;
   logic [SQ_CNT_W-1:0] sq_cnt_ff, sq_cnt_in;
   logic                sq_back_ff, sq_back_in;
   logic [OUT_W-1:0]    front_root_ff, front_root_in;
   logic                empty_ff, empty_in;
   logic [REM_W+1:0]    sq_cat, sq_trial, sq_diff;
   logic                sq_ge;
   logic [REM_W-1:0]    sq_rem_nx;
   logic [ROOT_W-1:0]   sq_root_nx;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_front_ff, rsp_front_in, rsp_back_ff, rsp_back_in;
   logic [OUT_W-1:0] rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;

   // shared decode
   logic               req_fire, idx_ok, mul_last, sq_last, out_free;
   logic               x_gt, y_neg, ay_gt_h;
   logic [15:0]        trig_t, scaled;
   logic [30:0]        round_sum;
   logic [ANG_W-1:0]   ang_q, cos_ang;
   logic [RANGE_W-1:0] o_ext, h_ext, dx, dy;
   logic [OUT_W-1:0]   t_clamp;

   assign req_fire  = req_valid && req_ready;
   assign idx_ok    = int'(req_sample_index) < MAX_SAMPLES;
   assign mul_last  = dig_ff == DIG_CNT_W'(MUL_DIGITS - 1);
   assign sq_last   = sq_cnt_ff == SQ_CNT_W'(SQ_STEPS - 1);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign o_ext     = {4'b0, offset_ff};
   assign h_ext     = {4'b0, half_w_ff};
   // x sign is the cosine sign; a zero magnitude never passes the compare
   assign x_gt      = !c_neg_ff && (x_mag_ff > o_ext);
   assign y_neg     = s_neg_ff && (y_mag_ff != '0);
   assign ay_gt_h   = y_mag_ff > h_ext;
   assign dx        = x_mag_ff - o_ext;
   assign dy        = y_mag_ff - h_ext;

   // products other than the corner squares stay below 2^31
   assign trig_t    = prod_ff[30:15];
   assign t_clamp   = clamp_q15(trig_t);
   assign round_sum = prod_ff[30:0] + ROUND_HALF;
   assign scaled    = round_sum[30:15];
   assign ang_q     = ((back_ff ? b_start_ff : f_start_ff) + prod_ff[15:0]) & ANGLE_MASK;
   assign cos_ang   = ang_ff + QUARTER;

   // one radix-16 digit of the multiplier per cycle, low digit first
   assign mul_sum   = {{DIGIT_W{1'b0}}, prod_ff[MUL_P_W-1:MUL_B_W]}
                    + MUL_SUM_W'(mul_a_ff) * MUL_SUM_W'(prod_ff[DIGIT_W-1:0]);

   // two bits of the radicand per cycle
   assign sq_cat     = {sq_rem_ff, sq_v_ff[SQ_W-1:SQ_W-2]};
   assign sq_trial   = {1'b0, sq_root_ff, 2'b01};
   assign sq_ge      = sq_cat >= sq_trial;
   assign sq_diff    = sq_cat - sq_trial;
   assign sq_rem_nx  = sq_ge ? sq_diff[REM_W-1:0] : sq_cat[REM_W-1:0];
   assign sq_root_nx = {sq_root_ff[ROOT_W-2:0], sq_ge};

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (cmd_type'(req_cmd))
                  CMD_FRONT, CMD_BACK: begin
                     if (idx_ok && req_range_mm != NO_RETURN) state_in = ST_MUL;
                  end
                  CMD_END: begin
                     state_in = (f_seen_ff && b_seen_ff) ? ST_SQRT : ST_DONE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL: begin
            if (mul_last) state_in = ST_POST;
         end
         ST_POST: begin
            case (op_ff)
               OP_Y:    state_in = x_gt ? ST_MUL : ST_UPDATE;
               OP_DX:   state_in = ay_gt_h ? ST_MUL : ST_UPDATE;
               OP_DY:   state_in = ST_UPDATE;
               default: state_in = ST_MUL;
            endcase
         end
         ST_UPDATE: state_in = ST_IDLE;
         ST_SQRT: begin
            if (sq_last && sq_back_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- handshake outputs
   always_comb begin
      req_ready    = state_ff == ST_IDLE;
      rsp_valid    = rsp_valid_ff;
      rsp_front_mm = rsp_front_ff;
      rsp_back_mm  = rsp_back_ff;
      rsp_left_mm  = rsp_left_ff;
      rsp_right_mm = rsp_right_ff;
   end

   // ---------------------------------------------------------------- configuration
   always_comb begin
      f_start_in = f_start_ff;
      f_step_in  = f_step_ff;
      b_start_in = b_start_ff;
      b_step_in  = b_step_ff;
      offset_in  = offset_ff;
      half_w_in  = half_w_ff;
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            REG_FRONT_START:  f_start_in = csr_wdata;
            REG_FRONT_STEP:   f_step_in  = csr_wdata;
            REG_BACK_START:   b_start_in = csr_wdata;
            REG_BACK_STEP:    b_step_in  = csr_wdata;
            REG_AHEAD_OFFSET: offset_in  = csr_wdata[DIST_W-1:0];
            REG_HALF_WIDTH:   half_w_in  = csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      op_in         = op_ff;
      dig_in        = dig_ff;
      mul_a_in      = mul_a_ff;
      prod_in       = prod_ff;
      back_in       = back_ff;
      range_in      = range_ff;
      ang_in        = ang_ff;
      z_in          = z_ff;
      z2_in         = z2_ff;
      s_mag_in      = s_mag_ff;
      s_neg_in      = s_neg_ff;
      c_neg_in      = c_neg_ff;
      x_mag_in      = x_mag_ff;
      y_mag_in      = y_mag_ff;
      d_in          = d_ff;
      f_ahead_in    = f_ahead_ff;
      b_ahead_in    = b_ahead_ff;
      f_sneg_in     = f_sneg_ff;
      f_spos_in     = f_spos_ff;
      b_spos_in     = b_spos_ff;
      b_sneg_in     = b_sneg_ff;
      f_seen_in     = f_seen_ff;
      b_seen_in     = b_seen_ff;
      sq_v_in       = sq_v_ff;
      sq_rem_in     = sq_rem_ff;
      sq_root_in    = sq_root_ff;
      sq_cnt_in     = sq_cnt_ff;
      sq_back_in    = sq_back_ff;
      front_root_in = front_root_ff;
      empty_in      = empty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (cmd_type'(req_cmd))
                  CMD_FRONT, CMD_BACK: begin
                     if (idx_ok) begin
                        if (req_cmd == CMD_BACK) b_seen_in = 1'b1;
                        else                     f_seen_in = 1'b1;
                     end
                     back_in  = req_cmd == CMD_BACK;
                     range_in = req_range_mm;
                     op_in    = OP_ANGLE;
                     dig_in   = '0;
                     mul_a_in = {1'b0, (req_cmd == CMD_BACK) ? b_step_ff : f_step_ff};
                     prod_in  = {{MUL_A_W{1'b0}}, {(MUL_B_W-IDX_W){1'b0}}, req_sample_index};
                  end
                  CMD_END: begin
                     empty_in   = !(f_seen_ff && b_seen_ff);
                     sq_v_in    = f_ahead_ff;
                     sq_rem_in  = '0;
                     sq_root_in = '0;
                     sq_cnt_in  = '0;
                     sq_back_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end

         ST_MUL: begin
            prod_in = {mul_sum, prod_ff[MUL_B_W-1:DIGIT_W]};
            dig_in  = mul_last ? '0 : dig_ff + 1'b1;
         end

         ST_POST: begin
            case (op_ff)
               OP_ANGLE: begin
                  ang_in   = ang_q;
                  z_in     = sine_z(ang_q);
                  mul_a_in = {1'b0, sine_z(ang_q)};
                  prod_in  = {{MUL_A_W{1'b0}}, 4'b0, sine_z(ang_q)};
                  op_in    = OP_SZ2;
               end
               OP_SZ2, OP_CZ2: begin
                  z2_in    = trig_t;
                  mul_a_in = SIN_C1;
                  prod_in  = {{MUL_A_W{1'b0}}, 4'b0, trig_t};
                  op_in    = (op_ff == OP_SZ2) ? OP_ST1 : OP_CT1;
               end
               OP_ST1, OP_CT1: begin
                  mul_a_in = SIN_C2 - {1'b0, trig_t};
                  prod_in  = {{MUL_A_W{1'b0}}, 4'b0, z2_ff};
                  op_in    = (op_ff == OP_ST1) ? OP_ST2 : OP_CT2;
               end
               OP_ST2, OP_CT2: begin
                  mul_a_in = SIN_C3 - {1'b0, trig_t};
                  prod_in  = {{MUL_A_W{1'b0}}, 4'b0, z_ff};
                  op_in    = (op_ff == OP_ST2) ? OP_ST3 : OP_CT3;
               end
               OP_ST3: begin
                  s_mag_in = t_clamp;
                  s_neg_in = ang_ff[ANG_W-1];
                  z_in     = sine_z(cos_ang);
                  mul_a_in = {1'b0, sine_z(cos_ang)};
                  prod_in  = {{MUL_A_W{1'b0}}, 4'b0, sine_z(cos_ang)};
                  op_in    = OP_CZ2;
               end
               OP_CT3: begin
                  c_neg_in = cos_ang[ANG_W-1];
                  mul_a_in = {2'b0, t_clamp};
                  prod_in  = {{MUL_A_W{1'b0}}, 4'b0, range_ff};
                  op_in    = OP_X;
               end
               OP_X: begin
                  x_mag_in = scaled;
                  mul_a_in = {2'b0, s_mag_ff};
                  prod_in  = {{MUL_A_W{1'b0}}, 4'b0, range_ff};
                  op_in    = OP_Y;
               end
               OP_Y: begin
                  y_mag_in = scaled;
                  mul_a_in = {1'b0, dx};
                  prod_in  = {{MUL_A_W{1'b0}}, 4'b0, dx};
                  op_in    = OP_DX;
               end
               OP_DX: begin
                  d_in     = prod_ff[SQ_W-1:0];
                  mul_a_in = {1'b0, dy};
                  prod_in  = {{MUL_A_W{1'b0}}, 4'b0, dy};
                  op_in    = OP_DY;
               end
               OP_DY: begin
                  d_in = d_ff + prod_ff[SQ_W-1:0];
               end
               default: ;
            endcase
         end

         ST_UPDATE: begin
            if (x_gt) begin
               if (back_ff) begin
                  if (d_ff < b_ahead_ff) b_ahead_in = d_ff;
               end else begin
                  if (d_ff < f_ahead_ff) f_ahead_in = d_ff;
               end
            end else if (!back_ff) begin
               // y <= -h, counting y = 0 when h = 0
               if (((y_neg && y_mag_ff >= h_ext) || (y_mag_ff == '0 && h_ext == '0))
                   && y_mag_ff < f_sneg_ff) f_sneg_in = y_mag_ff;
               if (!y_neg && ay_gt_h && y_mag_ff < f_spos_ff) f_spos_in = y_mag_ff;
            end else begin
               if (!y_neg && y_mag_ff >= h_ext && y_mag_ff < b_spos_ff) b_spos_in = y_mag_ff;
               if (y_neg && ay_gt_h && y_mag_ff < b_sneg_ff) b_sneg_in = y_mag_ff;
            end
         end

         ST_SQRT: begin
            sq_v_in    = {sq_v_ff[SQ_W-3:0], 2'b00};
            sq_rem_in  = sq_rem_nx;
            sq_root_in = sq_root_nx;
            sq_cnt_in  = sq_cnt_ff + 1'b1;
            if (sq_last && !sq_back_ff) begin
               front_root_in = sat_root(sq_root_nx);
               sq_v_in       = b_ahead_ff;
               sq_rem_in     = '0;
               sq_root_in    = '0;
               sq_cnt_in     = '0;
               sq_back_in    = 1'b1;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (empty_ff) begin
                  rsp_front_in = EMPTY_DEFAULT;
                  rsp_back_in  = EMPTY_DEFAULT;
                  rsp_left_in  = EMPTY_DEFAULT;
                  rsp_right_in = EMPTY_DEFAULT;
               end else begin
                  rsp_front_in = front_root_ff;
                  rsp_back_in  = sat_root(sq_root_ff);
                  rsp_left_in  = side_out(f_spos_ff, b_sneg_ff, half_w_ff);
                  rsp_right_in = side_out(f_sneg_ff, b_spos_ff, half_w_ff);
               end
               f_ahead_in = AHEAD_DEFAULT_SQ;
               b_ahead_in = AHEAD_DEFAULT_SQ;
               f_sneg_in  = SIDE_DEFAULT;
               f_spos_in  = SIDE_DEFAULT;
               b_spos_in  = SIDE_DEFAULT;
               b_sneg_in  = SIDE_DEFAULT;
               f_seen_in  = 1'b0;
               b_seen_in  = 1'b0;
            end
         end

         default: ;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_ANGLE;
         dig_ff       <= '0;
         sq_cnt_ff    <= '0;
         sq_back_ff   <= 1'b0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         f_start_ff   <= START_RESET;
         f_step_ff    <= STEP_RESET;
         b_start_ff   <= START_RESET;
         b_step_ff    <= STEP_RESET;
         offset_ff    <= OFFSET_RESET;
         half_w_ff    <= HALF_W_RESET;
         f_ahead_ff   <= AHEAD_DEFAULT_SQ;
         b_ahead_ff   <= AHEAD_DEFAULT_SQ;
         f_sneg_ff    <= SIDE_DEFAULT;
         f_spos_ff    <= SIDE_DEFAULT;
         b_spos_ff    <= SIDE_DEFAULT;
         b_sneg_ff    <= SIDE_DEFAULT;
         f_seen_ff    <= 1'b0;
         b_seen_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         dig_ff       <= dig_in;
         sq_cnt_ff    <= sq_cnt_in;
         sq_back_ff   <= sq_back_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         f_start_ff   <= f_start_in;
         f_step_ff    <= f_step_in;
         b_start_ff   <= b_start_in;
         b_step_ff    <= b_step_in;
         offset_ff    <= offset_in;
         half_w_ff    <= half_w_in;
         f_ahead_ff   <= f_ahead_in;
         b_ahead_ff   <= b_ahead_in;
         f_sneg_ff    <= f_sneg_in;
         f_spos_ff    <= f_spos_in;
         b_spos_ff    <= b_spos_in;
         b_sneg_ff    <= b_sneg_in;
         f_seen_ff    <= f_seen_in;
         b_seen_ff    <= b_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_a_ff      <= mul_a_in;
      prod_ff       <= prod_in;
      back_ff       <= back_in;
      range_ff      <= range_in;
      ang_ff        <= ang_in;
      z_ff          <= z_in;
      z2_ff         <= z2_in;
      s_mag_ff      <= s_mag_in;
      s_neg_ff      <= s_neg_in;
      c_neg_ff      <= c_neg_in;
      x_mag_ff      <= x_mag_in;
      y_mag_ff      <= y_mag_in;
      d_ff          <= d_in;
      sq_v_ff       <= sq_v_in;
      sq_rem_ff     <= sq_rem_in;
      sq_root_ff    <= sq_root_in;
      front_root_ff <= front_root_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
   end

   // ---------------------------------------------------------------- assertions
   `AST_IMPLIES(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "result beat raised outside the end state")
   `AST_ALWAYS(a_side_bound, clock, reset, f_sneg_ff <= SIDE_DEFAULT && f_spos_ff <= SIDE_DEFAULT && b_spos_ff <= SIDE_DEFAULT && b_sneg_ff <= SIDE_DEFAULT, "side minimum above its default")
   `AST_ALWAYS(a_ahead_bound, clock, reset, f_ahead_ff <= AHEAD_DEFAULT_SQ && b_ahead_ff <= AHEAD_DEFAULT_SQ, "ahead minimum above its default")
   `AST_IMPLIES(a_dy_needs_side, clock, reset, state_ff == ST_MUL && op_ff == OP_DY, ay_gt_h, "corner product started inside the half width")

endmodule
